@@ sv/toi_pkg.sv @@
`timescale 1ns / 1ps
// Package for the trapezoid oscillator integrator: state codes, fixed-point
// constants and the round/saturate helper. No dependencies.
package toi_pkg;

    localparam int H_FRAC    = 28;
    localparam int COEF_FRAC = 30;
    localparam logic [63:0] ONE_FX = 64'd1 << (2 * H_FRAC);
    localparam logic [63:0] SQRT_TOP_BIT = 64'd1 << 62;
    localparam logic [4:0] LAST_ITER = 5'd31;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_HSQ  = 9'b000000010,
        S_DIVC = 9'b000000100,
        S_DIVS = 9'b000001000,
        S_STEP = 9'b000010000,
        S_SQ   = 9'b000100000,
        S_SQRT = 9'b001000000,
        S_RND  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    // Shift right by COEF_FRAC with round half up, then clamp to 32 bits.
    function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] v);
        logic signed [63:0] t;
        logic signed [33:0] q;
        t = v + (64'sd1 <<< (COEF_FRAC - 1));
        q = 34'(t >>> COEF_FRAC);
        if (q > 34'sd2147483647)
            rnd_sat = 32'sh7FFFFFFF;
        else if (q < -34'sd2147483648)
            rnd_sat = 32'sh80000000;
        else
            rnd_sat = q[31:0];
    endfunction

endpackage

@@ sv/trapezoid_oscillator_integrator_top.sv @@
`timescale 1ns / 1ps
// Trapezoid-rule harmonic oscillator integrator with radius output.
// Uses toi_pkg; one shared multiplier and one shared subtractor under a sequencer.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+----------------------
//  in      | in_valid, in_ready, start_x, start_y      | start point, Q2.30
//  out     | out_valid, out_ready, final_x/y, radius   | final point and radius
//  cfg     | cfg_we, cfg_index, cfg_data               | step_size, step_count
//
// Throughput is bounded by the rotation step on the single multiplier and by
// the bit-serial divider and square root. in_ready is high only when the
// sequencer is idle; the output register holds a result while the next item
// is taken.
// Reset clears the sequencer and output valid; step_size to 0, step_count to 1.
module trapezoid_oscillator_integrator_top
    import toi_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [31:0]    start_x,
    input  logic signed [31:0]    start_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    final_x,
    output logic signed [31:0]    final_y,
    output logic        [31:0]    radius,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic        [31:0]    cfg_data
);

    state_t state_reg, state_next;

    logic [31:0]           step_size_reg;
    logic [COUNT_BITS-1:0] step_count_reg;

    logic signed [31:0] x_reg, y_reg, nx_reg, c_reg, s_reg;
    logic signed [63:0] acc_reg;
    logic [63:0]        den_reg, rem_reg, res_reg, bit_reg;
    logic [31:0]        quo_reg;
    logic               neg_reg;
    logic [4:0]         cnt_reg;
    logic [2:0]         ph_reg;
    logic [COUNT_BITS-1:0] n_reg;
    logic [31:0]        rad_reg;

    logic               out_valid_reg;
    logic signed [31:0] final_x_reg, final_y_reg;
    logic [31:0]        radius_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p_reg;

    logic [64:0] sub_a, sub_b;
    logic [65:0] diff;
    logic        ge;
    logic [64:0] div_rr;
    logic [31:0] q_fin;
    logic [30:0] q_mag;
    logic [61:0] hsq4;
    logic        load_out;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign final_x   = final_x_reg;
    assign final_y   = final_y_reg;
    assign radius    = radius_reg;

    assign hsq4   = mul_p_reg[63:2];
    assign div_rr = (cnt_reg == 5'd0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign q_fin  = {quo_reg[30:0], ge};
    assign q_mag  = 31'((33'(q_fin) + 33'd1) >> 1);
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_HSQ:
            begin
                mul_a = {1'b0, step_size_reg};
                mul_b = {1'b0, step_size_reg};
            end
            S_STEP:
            begin
                mul_a = (ph_reg == 3'd0 || ph_reg == 3'd3) ? 33'(c_reg) : 33'(s_reg);
                mul_b = (ph_reg == 3'd1 || ph_reg == 3'd3) ? 33'(y_reg) : 33'(x_reg);
            end
            S_SQ:
            begin
                mul_a = (ph_reg == 3'd0) ? 33'(x_reg) : 33'(y_reg);
                mul_b = mul_a;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // operand select for the shared subtractor
    always_comb
    begin
        if (state_reg == S_SQRT)
        begin
            sub_a = {1'b0, rem_reg};
            sub_b = {1'b0, res_reg + bit_reg};
        end
        else
        begin
            sub_a = div_rr;
            sub_b = {1'b0, den_reg};
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        ge   = !diff[65];
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_HSQ;
            S_HSQ:  if (ph_reg == 3'd1) state_next = S_DIVC;
            S_DIVC: if (cnt_reg == LAST_ITER) state_next = S_DIVS;
            S_DIVS:
                if (cnt_reg == LAST_ITER)
                    state_next = (step_count_reg == '0) ? S_SQ : S_STEP;
            S_STEP:
                if (ph_reg == 3'd4 && n_reg == step_count_reg - COUNT_BITS'(1))
                    state_next = S_SQ;
            S_SQ:   if (ph_reg == 3'd2) state_next = S_SQRT;
            S_SQRT: if (cnt_reg == LAST_ITER) state_next = S_RND;
            S_RND:  state_next = S_DONE;
            S_DONE: if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_size_reg  <= '0;
            step_count_reg <= COUNT_BITS'(1);
            out_valid_reg  <= 1'b0;
            ph_reg         <= '0;
            cnt_reg        <= '0;
            n_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == 1'b0)
                    step_size_reg <= cfg_data;
                else
                    step_count_reg <= cfg_data[COUNT_BITS-1:0];
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    ph_reg <= '0;
                end
                S_HSQ:
                begin
                    ph_reg  <= (ph_reg == 3'd1) ? 3'd0 : ph_reg + 3'd1;
                    cnt_reg <= '0;
                end
                S_DIVC, S_DIVS, S_SQRT:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    n_reg   <= '0;
                    ph_reg  <= '0;
                end
                S_STEP:
                begin
                    if (ph_reg == 3'd4)
                    begin
                        ph_reg <= '0;
                        n_reg  <= n_reg + COUNT_BITS'(1);
                    end
                    else
                        ph_reg <= ph_reg + 3'd1;
                end
                S_SQ:
                begin
                    ph_reg  <= (ph_reg == 3'd2) ? 3'd0 : ph_reg + 3'd1;
                    cnt_reg <= '0;
                end
                S_RND, S_DONE:
                begin
                    ph_reg <= '0;
                end
                default:
                begin
                    ph_reg <= '0;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_reg <= start_x;
                    y_reg <= start_y;
                end
            end
            S_HSQ:
            begin
                if (ph_reg == 3'd1)
                begin
                    den_reg <= ONE_FX + 64'(hsq4);
                    neg_reg <= (64'(hsq4) > ONE_FX);
                    rem_reg <= (64'(hsq4) > ONE_FX) ? 64'(hsq4) - ONE_FX
                                                    : ONE_FX - 64'(hsq4);
                    quo_reg <= '0;
                end
            end
            S_DIVC, S_DIVS:
            begin
                if (cnt_reg == LAST_ITER && state_reg == S_DIVC)
                begin
                    c_reg   <= neg_reg ? -32'(q_mag) : 32'(q_mag);
                    rem_reg <= 64'(step_size_reg) << H_FRAC;
                    quo_reg <= '0;
                end
                else
                begin
                    rem_reg <= ge ? diff[63:0] : div_rr[63:0];
                    quo_reg <= q_fin;
                    if (cnt_reg == LAST_ITER)
                        s_reg <= 32'(q_mag);
                end
            end
            S_STEP:
            begin
                unique case (ph_reg)
                    3'd1: acc_reg <= mul_p_reg[63:0];
                    3'd2: nx_reg  <= rnd_sat(acc_reg - mul_p_reg[63:0]);
                    3'd3: acc_reg <= mul_p_reg[63:0];
                    3'd4:
                    begin
                        x_reg <= nx_reg;
                        y_reg <= rnd_sat(acc_reg + mul_p_reg[63:0]);
                    end
                    default: acc_reg <= acc_reg;
                endcase
            end
            S_SQ:
            begin
                if (ph_reg == 3'd1)
                    acc_reg <= mul_p_reg[63:0];
                else if (ph_reg == 3'd2)
                begin
                    rem_reg <= acc_reg + mul_p_reg[63:0];
                    res_reg <= '0;
                    bit_reg <= SQRT_TOP_BIT;
                end
            end
            S_SQRT:
            begin
                if (ge)
                begin
                    rem_reg <= diff[63:0];
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            S_RND:
            begin
                if (res_reg[63:32] != '0)
                    rad_reg <= '1;
                else if (rem_reg > res_reg && res_reg[31:0] == '1)
                    rad_reg <= '1;
                else
                    rad_reg <= res_reg[31:0] + 32'(rem_reg > res_reg);
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    final_x_reg <= x_reg;
                    final_y_reg <= y_reg;
                    radius_reg  <= rad_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_HSQ))
        else $error("accepted item did not start the sequencer");

    a_sqrt_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT) |-> $onehot(bit_reg))
        else $error("square root bit register not one-hot");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> (n_reg < step_count_reg))
        else $error("step counter ran past step_count");

    a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && final_x == '0 && final_y == '0) |-> (radius == '0))
        else $error("nonzero radius at the origin");
`endif

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for trapezoid_oscillator_integrator_top: drives start points with bursty
// valid/ready traffic over several step settings and checks every result field
// against a fixed-point predictor. Depends on toi_pkg and the top module.
module testbench;
    import toi_pkg::*;

    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic        [31:0] rad;
    } orbit_end_t;

    class oscillator_scoreboard;
        logic [31:0] step_h;
        logic [15:0] step_n;
        orbit_end_t  expected_q[$];
        int          errors;

        function new();
            step_h = 0;
            step_n = 1;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == 1'b0)
                step_h = val;
            else
                step_n = val[15:0];
        endfunction

        function logic [63:0] coef_div(logic [63:0] num, logic [63:0] den);
            logic [63:0] q;
            logic [63:0] r;
            q = num / den;
            r = num - q * den;
            for (int i = 0; i < COEF_FRAC + 1; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= den)
                begin
                    r = r - den;
                    q[0] = 1'b1;
                end
            end
            return (q + 64'd1) >> 1;
        endfunction

        function logic signed [63:0] round_clamp(logic signed [63:0] v);
            logic signed [63:0] t;
            t = (v + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
            if (t > 64'sd2147483647)
                return 64'sd2147483647;
            if (t < -64'sd2147483648)
                return -64'sd2147483648;
            return t;
        endfunction

        function logic [63:0] root_round(logic [63:0] n);
            logic [63:0] res;
            logic [63:0] bitv;
            logic [63:0] rem;
            res = 0;
            bitv = 64'd1 << 62;
            rem = n;
            while (bitv > n)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (rem >= res + bitv)
                begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            if (rem > res)
                res = res + 1;
            return res;
        endfunction

        function void note_start(logic signed [31:0] sx, logic signed [31:0] sy);
            logic [63:0]        hw;
            logic [63:0]        hsq4;
            logic [63:0]        den;
            logic [63:0]        sq;
            logic [63:0]        r;
            logic signed [63:0] c;
            logic signed [63:0] s;
            logic signed [63:0] x;
            logic signed [63:0] y;
            logic signed [63:0] nx;
            orbit_end_t         e;
            hw = {32'd0, step_h};
            hsq4 = (hw * hw) >> 2;
            den = ONE_FX + hsq4;
            if (ONE_FX >= hsq4)
                c = $signed(coef_div(ONE_FX - hsq4, den));
            else
                c = -$signed(coef_div(hsq4 - ONE_FX, den));
            s = $signed(coef_div(hw << H_FRAC, den));
            x = sx;
            y = sy;
            for (int n = 0; n < step_n; n++)
            begin
                nx = round_clamp(c * x - s * y);
                y = round_clamp(s * x + c * y);
                x = nx;
            end
            sq = x * x + y * y;
            r = root_round(sq);
            if (r > 64'hFFFFFFFF)
                r = 64'hFFFFFFFF;
            e.fx = x[31:0];
            e.fy = y[31:0];
            e.rad = r[31:0];
            expected_q.push_back(e);
        endfunction

        function void check_result(logic signed [31:0] fx, logic signed [31:0] fy,
                                   logic [31:0] rad);
            orbit_end_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result x=%h y=%h radius=%h", fx, fy, rad);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (fx !== e.fx)
            begin
                $error("final_x expected %h actual %h", e.fx, fx);
                errors++;
            end
            if (fy !== e.fy)
            begin
                $error("final_y expected %h actual %h", e.fy, fy);
                errors++;
            end
            if (rad !== e.rad)
            begin
                $error("radius expected %h actual %h", e.rad, rad);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic signed [31:0] start_x = 0;
    logic signed [31:0] start_y = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic signed [31:0] final_x;
    logic signed [31:0] final_y;
    logic        [31:0] radius;
    logic               cfg_we = 0;
    logic               cfg_index = 0;
    logic        [31:0] cfg_data = 0;

    oscillator_scoreboard sb = new();
    int unsigned cycles = 0;
    int          starts_taken = 0;
    int          hold_left = 0;
    bit          hold_done = 0;
    int          burst_left = 0;

    trapezoid_oscillator_integrator_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .start_x(start_x), .start_y(start_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .final_x(final_x), .final_y(final_y), .radius(radius),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 4000000)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            sb.note_start(start_x, start_y);
            starts_taken <= starts_taken + 1;
        end
        if (rst_n && out_valid && out_ready)
            sb.check_result(final_x, final_y, radius);
    end

    // hold off the receiver once for a long stretch, otherwise stall at random in two of every three windows
    always @(negedge clk)
    begin
        if (!hold_done && starts_taken == 40)
        begin
            hold_done <= 1;
            hold_left <= 600;
            out_ready <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 0;
        end
        else if ((cycles / 700) % 3 == 0)
            out_ready <= 1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 6);
            repeat ($urandom_range(0, 20)) @(negedge clk);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1;
        start_x <= x;
        start_y <= y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        in_valid <= 0;
    endtask

    task automatic drain();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h7FFFFFFF);
            2: return -$signed($urandom_range(0, 32'h40000000));
            default: return $urandom_range(0, 32'h40000000);
        endcase
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // default registers: h = 0, one step
        send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_point(32'sh80000000, 32'sh80000000);
        send_point(32'sh7FFFFFFF, 32'sh80000000);
        send_point(0, 0);
        send_point(32'sh40000000, 0);
        send_point(-1, 1);
        drain();

        // h = 1.0: large points saturate
        write_reg(1'b0, 32'h10000000);
        write_reg(1'b1, 32'd1);
        send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_point(32'sh80000000, 32'sh7FFFFFFF);
        send_point(32'sh40000000, 32'shC0000000);
        send_point(32'sh00000001, 32'shFFFFFFFF);
        drain();

        // largest h: c near -1
        write_reg(1'b0, 32'hFFFFFFFF);
        write_reg(1'b1, 32'd3);
        send_point(32'sh40000000, 32'sh00000000);
        send_point(32'sh80000000, 32'sh7FFFFFFF);
        send_point(32'sh12345678, 32'shEDCBA987);
        drain();

        // longest run of steps
        write_reg(1'b0, 32'h00100000);
        write_reg(1'b1, 32'hFFFF);
        send_point(32'sh30000000, 32'shE0000000);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(1'b0, (ph == 0) ? 32'h0 : $urandom);
            write_reg(1'b1, $urandom_range(1, 40));
            for (int i = 0; i < 20; i++)
                send_point(rand_coord(), rand_coord());
            drain();
        end

        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

@@ files.f @@
sv/toi_pkg.sv
sv/trapezoid_oscillator_integrator_top.sv
tb/sv/testbench.sv
